>>> src/psr_pkg.sv
// Package for the point/segment relation unit: widths, relation and register
// codes, the square root cell word and the tolerance compare function.
// No dependencies.
package psr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int FRAC_BITS   = 12;
  localparam int TOL_FRAC    = 24;
  localparam int TOL_W       = 32;
  localparam int DIST_W      = 25;
  localparam int REL_W       = 3;
  localparam int CFG_IDX_W   = 2;

  localparam int DW     = COORD_WIDTH + 1;   // coordinate difference
  localparam int PROD_W = 2 * DW;            // one signed product
  localparam int A_W    = 2 * DW - 1;        // squared length
  localparam int BCT_W  = 2 * DW;            // signed dot product
  localparam int ROOT_W = A_W;
  localparam int RAD_W  = 2 * ROOT_W;        // radicand, holds a*b
  localparam int REM_W  = ROOT_W + 3;
  localparam int LO_W   = (A_W + 1) / 2;
  localparam int HI_W   = A_W - LO_W;
  localparam int D2_W   = BCT_W + 1;
  localparam int F1     = FRAC_BITS;
  localparam int F2     = 2 * FRAC_BITS;

  localparam logic [REL_W-1:0] REL_INSIDE = 3'd0;
  localparam logic [REL_W-1:0] REL_START  = 3'd1;
  localparam logic [REL_W-1:0] REL_END    = 3'd2;
  localparam logic [REL_W-1:0] REL_PAST   = 3'd3;
  localparam logic [REL_W-1:0] REL_BEHIND = 3'd4;
  localparam logic [REL_W-1:0] REL_OFF    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_TOL   = 2'd2;

  localparam logic [TOL_W-1:0] TOL_RST   = 32'd0;
  localparam logic [TOL_W-1:0] FLOOR_RST = 32'd1;
  localparam logic [TOL_W-1:0] DEF_RST   = 32'd17;

  // word handed from one square root cell to the next
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [A_W-1:0]          a;
    logic [A_W-1:0]          b;
    logic signed [BCT_W-1:0] bct;
    logic [RAD_W-1:0]        ab;
    logic                    start_hit;
    logic                    a_lt_b;
  } front_t;

  // exact test x * 2^-fx < tol * 2^-24
  function automatic logic below_tol(input logic [63:0] x, input int fx,
                                     input logic [TOL_W-1:0] tol);
    logic [63:0] t64;
    logic [63:0] lim;
    t64 = {{(64 - TOL_W){1'b0}}, tol};
    if (fx >= TOL_FRAC) begin
      lim = t64 << (fx - TOL_FRAC);
    end else begin
      lim = (t64 + (64'd1 << (TOL_FRAC - fx)) - 64'd1) >> (TOL_FRAC - fx);
    end
    return x < lim;
  endfunction

endpackage

>>> src/psr_sqrt_cell.sv
// One digit step of a restoring square root, registered.
// Depends on psr_pkg.
module psr_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  psr_pkg::sqrt_t d,
  output psr_pkg::sqrt_t q
);

  logic [psr_pkg::REM_W-1:0] rem_sh;
  logic [psr_pkg::REM_W-1:0] trial;
  logic                      take;
  psr_pkg::sqrt_t            q_nxt;

  always_comb begin
    rem_sh = {d.rem[psr_pkg::REM_W-3:0], d.rad[psr_pkg::RAD_W-1 -: 2]};
    trial  = psr_pkg::REM_W'({d.root, 2'b01});
    take   = rem_sh >= trial;
    q_nxt.rad  = {d.rad[psr_pkg::RAD_W-3:0], 2'b00};
    q_nxt.rem  = take ? rem_sh - trial : rem_sh;
    q_nxt.root = {d.root[psr_pkg::ROOT_W-2:0], take};
  end

  // advance only with the rest of the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_nxt;
    end
  end

endmodule

>>> src/psr_front.sv
// Front end: differences, products, squared lengths, dot product and a*b.
// Five register stages. Depends on psr_pkg.
module psr_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  valid_i,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] start_x,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] start_y,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] end_x,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] end_y,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] point_y,
  input  logic [psr_pkg::TOL_W-1:0]             tol,
  output logic                                  valid_o,
  output psr_pkg::front_t                       q
);

  logic [4:0] v_r;

  logic signed [psr_pkg::DW-1:0] dpx_r, dpy_r, dex_r, dey_r;
  logic signed [psr_pkg::PROD_W-1:0] px2_r, py2_r, ex2_r, ey2_r, bx_r, by_r;
  logic [psr_pkg::A_W-1:0] a3_r, b3_r, a4_r, b4_r, a5_r, b5_r;
  logic signed [psr_pkg::BCT_W-1:0] bct3_r, bct4_r, bct5_r;
  logic sh4_r, lt4_r, sh5_r, lt5_r;
  logic [2*psr_pkg::LO_W-1:0] ll_r;
  logic [psr_pkg::LO_W+psr_pkg::HI_W-1:0] lh_r, hl_r;
  logic [2*psr_pkg::HI_W-1:0] hh_r;
  logic [psr_pkg::RAD_W-1:0] ab5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpx_r <= psr_pkg::DW'(point_x) - psr_pkg::DW'(start_x);
      dpy_r <= psr_pkg::DW'(point_y) - psr_pkg::DW'(start_y);
      dex_r <= psr_pkg::DW'(end_x) - psr_pkg::DW'(start_x);
      dey_r <= psr_pkg::DW'(end_y) - psr_pkg::DW'(start_y);

      px2_r <= dpx_r * dpx_r;
      py2_r <= dpy_r * dpy_r;
      ex2_r <= dex_r * dex_r;
      ey2_r <= dey_r * dey_r;
      bx_r  <= dpx_r * dex_r;
      by_r  <= dpy_r * dey_r;

      a3_r   <= psr_pkg::A_W'($unsigned(px2_r + py2_r));
      b3_r   <= psr_pkg::A_W'($unsigned(ex2_r + ey2_r));
      bct3_r <= bx_r + by_r;

      // split a*b into partial products of half width
      ll_r   <= a3_r[psr_pkg::LO_W-1:0] * b3_r[psr_pkg::LO_W-1:0];
      lh_r   <= a3_r[psr_pkg::LO_W-1:0] * b3_r[psr_pkg::A_W-1:psr_pkg::LO_W];
      hl_r   <= a3_r[psr_pkg::A_W-1:psr_pkg::LO_W] * b3_r[psr_pkg::LO_W-1:0];
      hh_r   <= a3_r[psr_pkg::A_W-1:psr_pkg::LO_W] * b3_r[psr_pkg::A_W-1:psr_pkg::LO_W];
      a4_r   <= a3_r;
      b4_r   <= b3_r;
      bct4_r <= bct3_r;
      sh4_r  <= psr_pkg::below_tol(64'(a3_r), psr_pkg::F2, tol);
      lt4_r  <= a3_r < b3_r;

      ab5_r  <= psr_pkg::RAD_W'(ll_r)
              + (psr_pkg::RAD_W'(lh_r) << psr_pkg::LO_W)
              + (psr_pkg::RAD_W'(hl_r) << psr_pkg::LO_W)
              + (psr_pkg::RAD_W'(hh_r) << (2 * psr_pkg::LO_W));
      a5_r   <= a4_r;
      b5_r   <= b4_r;
      bct5_r <= bct4_r;
      sh5_r  <= sh4_r;
      lt5_r  <= lt4_r;
    end
  end

  assign valid_o     = v_r[4];
  assign q.a         = a5_r;
  assign q.b         = b5_r;
  assign q.bct       = bct5_r;
  assign q.ab        = ab5_r;
  assign q.start_hit = sh5_r;
  assign q.a_lt_b    = lt5_r;

endmodule

>>> src/point_segment_relation_unit.sv
// Top level of the point/segment relation unit: config registers, square root
// cell chains and classification. Depends on psr_pkg, psr_front, psr_sqrt_cell.
//
// Use: present a segment (start, end) and a query point, signed Q12.12, on the
// in_ channel; each word returns one out_ word with the relation code
// (0 inside, 1 at start, 2 at end, 3 past end, 4 behind start, 5 off line)
// and the truncated start-to-point distance, unsigned Q13.12.
// A word is taken on a rising edge with valid high and stall low, on both
// channels. Configuration (tolerance, floor, default tolerance, Q8.24) must be
// written through cfg_we/cfg_index/cfg_data while no word is in flight; the
// block itself does not enforce this. Throughput: one word per cycle while the
// receiver does not stall. Latency is set by two chains of ROOT_W square
// root cells, one digit each: one for sqrt(a), sqrt(b), sqrt(a*b), then one for the
// final root. The whole pipeline moves as one: while the output register
// holds a word the receiver stalls, every stage holds and in_stall is raised.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// register defaults: tolerance 0, floor 1, default tolerance 17.
module point_segment_relation_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] in_start_x,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] in_start_y,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] in_end_x,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] in_end_y,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] in_point_x,
  input  logic signed [psr_pkg::COORD_WIDTH-1:0] in_point_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [psr_pkg::REL_W-1:0]             out_relation,
  output logic [psr_pkg::DIST_W-1:0]            out_start_distance,
  input  logic                                  cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psr_pkg::TOL_W-1:0]             cfg_data
);

  localparam int N = psr_pkg::ROOT_W;

  typedef struct packed {
    logic signed [psr_pkg::BCT_W-1:0] bct;
    logic                             start_hit;
    logic                             a_lt_b;
  } side1_t;

  typedef struct packed {
    logic                      start_hit;
    logic                      end_hit;
    logic                      on_line;
    logic                      a_lt_b;
    logic [psr_pkg::DIST_W-1:0] ra;
  } side2_t;

  // configuration registers
  logic [psr_pkg::TOL_W-1:0] tol_r, floor_r, dflt_r, tol_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= psr_pkg::TOL_RST;
      floor_r <= psr_pkg::FLOOR_RST;
      dflt_r  <= psr_pkg::DEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psr_pkg::REG_TOLERANCE: tol_r   <= cfg_data;
        psr_pkg::REG_TOL_FLOOR: floor_r <= cfg_data;
        psr_pkg::REG_DEF_TOL:   dflt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // fall back to the default when the given tolerance is under the floor
  assign tol_eff = (tol_r < floor_r) ? dflt_r : tol_r;

  logic adv;
  logic out_valid_r;
  logic [psr_pkg::REL_W-1:0]  relation_r, relation_nxt;
  logic [psr_pkg::DIST_W-1:0] dist_r;

  // hold everything while a finished word waits on a stalled receiver
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic            fv;
  psr_pkg::front_t fq;

  psr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (in_valid),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .point_x (in_point_x),
    .point_y (in_point_y),
    .tol     (tol_eff),
    .valid_o (fv),
    .q       (fq)
  );

  // first chain: three lanes of root cells side by side
  psr_pkg::sqrt_t lane_a [N+1];
  psr_pkg::sqrt_t lane_b [N+1];
  psr_pkg::sqrt_t lane_p [N+1];
  psr_pkg::sqrt_t lane_d [N+1];

  assign lane_a[0] = '{rad: psr_pkg::RAD_W'(fq.a), rem: '0, root: '0};
  assign lane_b[0] = '{rad: psr_pkg::RAD_W'(fq.b), rem: '0, root: '0};
  assign lane_p[0] = '{rad: fq.ab, rem: '0, root: '0};

  for (genvar i = 0; i < N; i++) begin : g_chain1
    psr_sqrt_cell u_ca (.clk(clk), .en(adv), .d(lane_a[i]), .q(lane_a[i+1]));
    psr_sqrt_cell u_cb (.clk(clk), .en(adv), .d(lane_b[i]), .q(lane_b[i+1]));
    psr_sqrt_cell u_cp (.clk(clk), .en(adv), .d(lane_p[i]), .q(lane_p[i+1]));
  end

  logic [N-1:0] v1_r;
  side1_t       s1_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= '0;
    end else if (adv) begin
      v1_r <= {v1_r[N-2:0], fv};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r[0] <= '{bct: fq.bct, start_hit: fq.start_hit, a_lt_b: fq.a_lt_b};
      for (int i = 1; i < N; i++) begin
        s1_r[i] <= s1_r[i-1];
      end
    end
  end

  // mid stage: distances from the roots, tolerance tests
  logic [psr_pkg::ROOT_W-1:0] ra, rb, len, d1;
  logic signed [psr_pkg::D2_W-1:0] t2;
  logic [psr_pkg::D2_W-1:0] d2;
  logic [psr_pkg::BCT_W-1:0] abs_bct, d3;
  logic [psr_pkg::BCT_W-1:0] len_x;

  always_comb begin
    ra    = lane_a[N].root;
    rb    = lane_b[N].root;
    len   = lane_p[N].root;
    d1    = (ra >= rb) ? ra - rb : rb - ra;
    t2    = psr_pkg::D2_W'(s1_r[N-1].bct) - $signed({2'b00, len});
    d2    = t2[psr_pkg::D2_W-1] ? psr_pkg::D2_W'(-t2) : psr_pkg::D2_W'(t2);
    abs_bct = s1_r[N-1].bct[psr_pkg::BCT_W-1] ?
              psr_pkg::BCT_W'(-s1_r[N-1].bct) : psr_pkg::BCT_W'(s1_r[N-1].bct);
    len_x = psr_pkg::BCT_W'(len);
    d3    = (abs_bct >= len_x) ? abs_bct - len_x : len_x - abs_bct;
  end

  logic   vm_r;
  side2_t sm_r;
  logic [psr_pkg::BCT_W-1:0] d3_r;
  logic   on_line;

  assign on_line = psr_pkg::below_tol(64'(d2), psr_pkg::F2, tol_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (adv) begin
      vm_r <= v1_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r.start_hit <= s1_r[N-1].start_hit;
      sm_r.end_hit   <= psr_pkg::below_tol(64'(d1), psr_pkg::F1, tol_eff) && on_line;
      sm_r.on_line   <= on_line;
      sm_r.a_lt_b    <= s1_r[N-1].a_lt_b;
      sm_r.ra        <= ra[psr_pkg::DIST_W-1:0];
      d3_r           <= d3;
    end
  end

  // second chain: root of the dot product mismatch
  assign lane_d[0] = '{rad: psr_pkg::RAD_W'(d3_r), rem: '0, root: '0};

  for (genvar i = 0; i < N; i++) begin : g_chain2
    psr_sqrt_cell u_cd (.clk(clk), .en(adv), .d(lane_d[i]), .q(lane_d[i+1]));
  end

  logic [N-1:0] v2_r;
  side2_t       s2_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= '0;
    end else if (adv) begin
      v2_r <= {v2_r[N-2:0], vm_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r[0] <= sm_r;
      for (int i = 1; i < N; i++) begin
        s2_r[i] <= s2_r[i-1];
      end
    end
  end

  // classify, first matching test wins
  logic behind;

  always_comb begin
    behind = psr_pkg::below_tol(64'(lane_d[N].root), psr_pkg::F1, tol_eff);
    if (s2_r[N-1].start_hit) begin
      relation_nxt = psr_pkg::REL_START;
    end else if (s2_r[N-1].end_hit) begin
      relation_nxt = psr_pkg::REL_END;
    end else if (s2_r[N-1].on_line) begin
      relation_nxt = s2_r[N-1].a_lt_b ? psr_pkg::REL_INSIDE : psr_pkg::REL_PAST;
    end else if (behind) begin
      relation_nxt = psr_pkg::REL_BEHIND;
    end else begin
      relation_nxt = psr_pkg::REL_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      relation_r <= relation_nxt;
      dist_r     <= s2_r[N-1].ra;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_relation       = relation_r;
  assign out_start_distance = dist_r;

  a_rel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (relation_r != 3'd6 && relation_r != 3'd7))
    else $error("relation code out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(v1_r) && $stable(v2_r) && $stable(vm_r)))
    else $error("pipeline moved while output stalled");

  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r[N-1]) |=> out_valid_r)
    else $error("finished word lost at output");

endmodule

>>> tb/point_segment_relation_unit_test.sv
// Testbench for point_segment_relation_unit: random and directed segment/point
// queries checked against a behavioral classifier. Depends on psr_pkg and the RTL.
module point_segment_relation_unit_test;

  localparam int RUN_LIMIT   = 400000;  // cycles, many times the slowest run
  localparam int DRAIN_WAIT  = 2 * psr_pkg::ROOT_W + 40;

  typedef logic signed [psr_pkg::COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [psr_pkg::REL_W-1:0]  relation;
    logic [psr_pkg::DIST_W-1:0] start_distance;
  } relation_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t in_start_x, in_start_y, in_end_x, in_end_y, in_point_x, in_point_y;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [psr_pkg::REL_W-1:0] out_relation;
  logic [psr_pkg::DIST_W-1:0] out_start_distance;
  logic cfg_we;
  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [psr_pkg::TOL_W-1:0] cfg_data;

  // shadow copy of the tolerance registers
  logic [psr_pkg::TOL_W-1:0] tol_value, tol_floor, tol_default;

  relation_word_t expected_relations[$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left;

  point_segment_relation_unit u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // truncated square root of a 128-bit radicand
  function automatic logic [63:0] trunc_root(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int k = 62; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // exact compare of x (fx fraction bits) against a Q8.24 tolerance
  function automatic logic under_tolerance(input logic [63:0] x, input int fx,
                                           input logic [psr_pkg::TOL_W-1:0] tol);
    logic [63:0] t;
    int s;
    t = {32'd0, tol};
    if (fx >= psr_pkg::TOL_FRAC) return x < (t << (fx - psr_pkg::TOL_FRAC));
    s = psr_pkg::TOL_FRAC - fx;
    return x < ((t + (64'd1 << s) - 64'd1) >> s);
  endfunction

  function automatic relation_word_t classify_point(input coord_t sx, input coord_t sy,
                                                    input coord_t ex, input coord_t ey,
                                                    input coord_t px, input coord_t py);
    longint dpx, dpy, dex, dey, bct, a, b, len, ra, rb, d1, d2, abs_bct, d3;
    logic [psr_pkg::TOL_W-1:0] tol;
    relation_word_t w;
    dpx = longint'(px) - longint'(sx);
    dpy = longint'(py) - longint'(sy);
    dex = longint'(ex) - longint'(sx);
    dey = longint'(ey) - longint'(sy);
    bct = dpx * dex + dpy * dey;
    a = dpx * dpx + dpy * dpy;
    b = dex * dex + dey * dey;
    tol = (tol_value < tol_floor) ? tol_default : tol_value;
    len = trunc_root({64'd0, a} * {64'd0, b});
    ra = trunc_root({64'd0, a});
    rb = trunc_root({64'd0, b});
    d1 = (ra >= rb) ? ra - rb : rb - ra;
    d2 = (bct >= len) ? bct - len : len - bct;
    w.start_distance = ra[psr_pkg::DIST_W-1:0];
    if (under_tolerance(a, psr_pkg::F2, tol)) begin
      w.relation = psr_pkg::REL_START;
    end else if (under_tolerance(d1, psr_pkg::F1, tol) &&
                 under_tolerance(d2, psr_pkg::F2, tol)) begin
      w.relation = psr_pkg::REL_END;
    end else if (under_tolerance(d2, psr_pkg::F2, tol)) begin
      w.relation = (a < b) ? psr_pkg::REL_INSIDE : psr_pkg::REL_PAST;
    end else begin
      abs_bct = (bct < 0) ? -bct : bct;
      d3 = (abs_bct >= len) ? abs_bct - len : len - abs_bct;
      w.relation = under_tolerance(trunc_root({64'd0, d3}), psr_pkg::F1, tol) ?
                   psr_pkg::REL_BEHIND : psr_pkg::REL_OFF;
    end
    return w;
  endfunction

  // Drive one query word and hold it until taken; then maybe open a gap.
  task automatic send_query(input coord_t sx, input coord_t sy, input coord_t ex,
                            input coord_t ey, input coord_t px, input coord_t py);
    int gap;
    in_valid   <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (in_stall);
    expected_relations.push_back(classify_point(sx, sy, ex, ey, px, py));
    // bursts of back-to-back words separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all words in flight, then write one register.
  task automatic write_register(input logic [psr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [psr_pkg::TOL_W-1:0] v);
    in_valid <= 1'b0;
    wait (expected_relations.size() == 0);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psr_pkg::REG_TOLERANCE: tol_value   = v;
      psr_pkg::REG_TOL_FLOOR: tol_floor   = v;
      psr_pkg::REG_DEF_TOL:   tol_default = v;
      default: ;
    endcase
  endtask

  // Send a segment with a point at k/2 of its length, plus small jitter.
  task automatic send_on_line(input int span, input int jitter);
    int sx, sy, dx, dy, k, qx, qy;
    sx = $urandom_range(0, 2 ** 21) - 2 ** 20;
    sy = $urandom_range(0, 2 ** 21) - 2 ** 20;
    dx = $urandom_range(0, 2 * span) - span;
    dy = $urandom_range(0, 2 * span) - span;
    k  = $urandom_range(0, 7) - 3;
    qx = sx + (k * dx) / 2 + $urandom_range(0, 2 * jitter) - jitter;
    qy = sy + (k * dy) / 2 + $urandom_range(0, 2 * jitter) - jitter;
    send_query(coord_t'(sx), coord_t'(sy), coord_t'(sx + dx), coord_t'(sy + dy),
               coord_t'(qx), coord_t'(qy));
  endtask

  task automatic send_any;
    send_query(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Hand-picked cases: start, end, inside, past end, behind, off line,
  // a degenerate segment and the coordinate extremes.
  task automatic test_directed_cases;
    send_query(0, 0, 0, 0, 0, 0);
    send_query(4096, 4096, 8192, 8192, 4096, 4096);
    send_query(0, 0, 40960, 0, 40960, 0);
    send_query(0, 0, 40960, 0, 20480, 0);
    send_query(0, 0, 40960, 0, 81920, 0);
    send_query(0, 0, 40960, 0, -20480, 0);
    send_query(0, 0, 40960, 0, 20480, 8192);
    send_query(100, -100, 100, -100, 5000, 3000);
    send_query(-8388608, -8388608, 8388607, 8388607, 0, 0);
    send_query(8388607, -8388608, -8388608, 8388607, 8388607, 8388607);
    send_query(-8388608, -8388608, -8388608, -8388608, 8388607, 8388607);
    send_query(8388607, 8388607, -8388608, -8388608, -8388608, -8388608);
    send_query(0, 0, 1, 0, 2, 0);
    send_query(0, 0, 3, 4, 0, 1);
  endtask

  task automatic test_reset_defaults;
    test_directed_cases();
    repeat (60) send_on_line(4000, 0);
    repeat (20) send_any();
  endtask

  // A tolerance of one unit: wide bands around the segment.
  task automatic test_wide_tolerance;
    write_register(psr_pkg::REG_TOLERANCE, 32'h0100_0000);
    test_directed_cases();
    repeat (70) send_on_line(20000, 300);
    repeat (10) send_any();
  endtask

  // Floor at its maximum forces the default; try default at both extremes.
  task automatic test_floor_fallback;
    write_register(psr_pkg::REG_TOL_FLOOR, 32'hFFFF_FFFF);
    write_register(psr_pkg::REG_DEF_TOL, 32'd0);
    repeat (40) send_on_line(2000, 2);
    write_register(psr_pkg::REG_DEF_TOL, 32'hFFFF_FFFF);
    test_directed_cases();
    repeat (40) send_on_line(60000, 1000);
  endtask

  task automatic test_extreme_registers;
    write_register(psr_pkg::REG_TOL_FLOOR, 32'd0);
    write_register(psr_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
    repeat (40) send_on_line(100000, 50);
    write_register(psr_pkg::REG_TOLERANCE, 32'd0);
    repeat (40) send_on_line(3000, 0);
  endtask

  task automatic test_random_mix;
    for (int p = 0; p < 4; p++) begin
      write_register(psr_pkg::REG_TOLERANCE,
                     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 ** 22));
      write_register(psr_pkg::REG_TOL_FLOOR, $urandom_range(0, 2 ** 12));
      write_register(psr_pkg::REG_DEF_TOL, $urandom_range(0, 2 ** 20));
      repeat (25) begin
        if ($urandom_range(0, 3) == 0) send_any();
        else send_on_line($urandom_range(1, 50000), $urandom_range(0, 20));
      end
    end
  endtask

  // Receiver stall pattern: a random mode, picked anew when cycle_count is a multiple of 64.
  logic [1:0] stall_mode = 2'd0;
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= $urandom_range(0, 1);
      2'd2: out_stall <= (cycle_count % 4 != 0);
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Compare each taken result word with the oldest expectation.
  always @(posedge clk) begin
    relation_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_relations.size() == 0) begin
        $error("unexpected result word relation=%0d start_distance=%0d",
               out_relation, out_start_distance);
        error_count++;
      end else begin
        want = expected_relations.pop_front();
        if (out_relation !== want.relation) begin
          $error("relation: expected %0d, got %0d", want.relation, out_relation);
          error_count++;
        end
        if (out_start_distance !== want.start_distance) begin
          $error("start_distance: expected %0d, got %0d",
                 want.start_distance, out_start_distance);
          error_count++;
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    in_point_x = '0;
    in_point_y = '0;
    cfg_we = 1'b0;
    cfg_index = psr_pkg::REG_TOLERANCE;
    cfg_data = '0;
    burst_left = 0;
    tol_value = psr_pkg::TOL_RST;
    tol_floor = psr_pkg::FLOOR_RST;
    tol_default = psr_pkg::DEF_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_wide_tolerance();
    test_floor_fallback();
    test_extreme_registers();
    test_random_mix();
    in_valid <= 1'b0;
    wait (expected_relations.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_relations.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
